// ===== src/raq_pkg.sv =====
package raq_pkg;

    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = 11;
    localparam int OPND_W  = 32;
    localparam int ELEM_W  = 32;
    localparam int RIDX_W  = 10;
    localparam int CNT_W   = $clog2(OPND_W + 1);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ROT_ACW = 2'd1,
        REQ_ROT_CW  = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req;

    typedef struct packed {
        t_req                     req_type;
        logic        [OPND_W-1:0] operand;
        logic signed [ELEM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic        [RIDX_W-1:0] read_index;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_OFF_RUN,
        ST_OPND_RUN,
        ST_READ
    } t_state;

    typedef struct packed {
        logic capture;
        logic mod_start;
        logic mod_off;
        logic off_load;
        logic mem_write;
        logic rot_apply;
        logic mem_read;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic off_stale;
        logic mod_idle;
        logic out_free;
    } t_sts;

endpackage

// ===== src/raq_mod.sv =====
module raq_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_off_pass,
    input  logic [raq_pkg::IDX_W-1:0]    i_offset,
    input  logic [raq_pkg::OPND_W-1:0]   i_opnd,
    input  logic [raq_pkg::LEN_W-1:0]    i_len,
    output logic                         o_idle,
    output logic [raq_pkg::IDX_W-1:0]    o_rem
);

    logic                         r_busy;
    logic [raq_pkg::CNT_W-1:0]    r_cnt;
    logic [raq_pkg::OPND_W-1:0]   r_div;
    logic [raq_pkg::IDX_W-1:0]    r_rem;

    logic [raq_pkg::IDX_W:0]      trial;
    logic [raq_pkg::LEN_W:0]      trial_ext;
    logic [raq_pkg::LEN_W:0]      len_ext;
    logic [raq_pkg::LEN_W:0]      diff;
    logic [raq_pkg::IDX_W-1:0]    n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial     = {r_rem, r_div[raq_pkg::OPND_W-1]};
        trial_ext = (raq_pkg::LEN_W + 1)'(trial);
        len_ext   = (raq_pkg::LEN_W + 1)'(i_len);
        diff      = trial_ext - len_ext;
        if (trial_ext >= len_ext) begin
            n_rem = diff[raq_pkg::IDX_W-1:0];
        end else begin
            n_rem = trial[raq_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_off_pass ? raq_pkg::CNT_W'(raq_pkg::IDX_W)
                                 : raq_pkg::CNT_W'(raq_pkg::OPND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == raq_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_off_pass
                ? {i_offset, {(raq_pkg::OPND_W - raq_pkg::IDX_W){1'b0}}}
                : i_opnd;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_div <= {r_div[raq_pkg::OPND_W-2:0], 1'b0};
        end
    end

    assign o_idle = !r_busy;
    assign o_rem  = r_rem;

endmodule

// ===== src/raq_dp.sv =====
module raq_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [raq_pkg::LEN_W-1:0]    i_cfg_data,
    input  raq_pkg::t_in_item            i_in_item,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output raq_pkg::t_out_item           o_out_item,
    input  raq_pkg::t_cmd                i_cmd,
    output raq_pkg::t_sts                o_sts
);

    logic [raq_pkg::LEN_W-1:0]    r_len;
    logic                         r_off_stale;
    logic [raq_pkg::IDX_W-1:0]    r_off;
    raq_pkg::t_in_item            r_item;
    logic [raq_pkg::ELEM_W-1:0]   r_mem [raq_pkg::MAX_LEN];
    logic [raq_pkg::ELEM_W-1:0]   r_rd_data;
    logic [raq_pkg::IDX_W-1:0]    r_rd_idx;
    logic                         r_out_valid;
    raq_pkg::t_out_item           r_out_item;

    logic [raq_pkg::LEN_W-1:0]    eff_len;
    logic                         mod_idle;
    logic [raq_pkg::IDX_W-1:0]    amt;
    logic                         load_ok;
    logic [raq_pkg::LEN_W:0]      sum;
    logic [raq_pkg::LEN_W:0]      len_ext;
    logic [raq_pkg::LEN_W:0]      off_ext;
    logic [raq_pkg::LEN_W:0]      amt_ext;
    logic [raq_pkg::LEN_W:0]      p1;
    logic [raq_pkg::LEN_W:0]      pos_full;
    logic [raq_pkg::IDX_W-1:0]    n_off;
    logic [raq_pkg::IDX_W-1:0]    pos;

    // A length of zero acts as one, and a length above the store depth is clamped.
    always_comb begin
        if (r_len == '0) begin
            eff_len = raq_pkg::LEN_W'(1);
        end else if (r_len > raq_pkg::LEN_W'(raq_pkg::MAX_LEN)) begin
            eff_len = raq_pkg::LEN_W'(raq_pkg::MAX_LEN);
        end else begin
            eff_len = r_len;
        end
    end

    raq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_off_pass (i_cmd.mod_off),
        .i_offset   (r_off),
        .i_opnd     (r_item.operand),
        .i_len      (eff_len),
        .o_idle     (mod_idle),
        .o_rem      (amt)
    );

    assign load_ok = r_item.operand < raq_pkg::OPND_W'(eff_len);

    always_comb begin
        len_ext = (raq_pkg::LEN_W + 1)'(eff_len);
        off_ext = (raq_pkg::LEN_W + 1)'(r_off);
        amt_ext = (raq_pkg::LEN_W + 1)'(amt);
        if (r_item.req_type == raq_pkg::REQ_ROT_ACW) begin
            sum = off_ext + amt_ext;
            if (sum >= len_ext) begin
                sum = sum - len_ext;
            end
        end else if (amt_ext > off_ext) begin
            sum = off_ext + len_ext - amt_ext;
        end else begin
            sum = off_ext - amt_ext;
        end
        n_off = sum[raq_pkg::IDX_W-1:0];

        if (amt == '0) begin
            p1 = len_ext - 1'b1;
        end else begin
            p1 = amt_ext - 1'b1;
        end
        if (p1 >= off_ext) begin
            pos_full = p1 - off_ext;
        end else begin
            pos_full = p1 + len_ext - off_ext;
        end
        pos = pos_full[raq_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= raq_pkg::LEN_W'(1);
            r_off       <= '0;
            r_off_stale <= 1'b0;
        end else begin
            if (i_cmd.off_load) begin
                r_off       <= amt;
                r_off_stale <= 1'b0;
            end else if (i_cmd.rot_apply) begin
                r_off <= n_off;
            end
            if (i_cfg_we) begin
                r_len       <= i_cfg_data;
                r_off_stale <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && load_ok) begin
            r_mem[r_item.operand[raq_pkg::IDX_W-1:0]] <= r_item.value;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[pos];
            r_rd_idx  <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.element    <= r_rd_data;
            r_out_item.read_index <= raq_pkg::RIDX_W'(r_rd_idx);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;
    assign o_sts.req       = r_item.req_type;
    assign o_sts.off_stale = r_off_stale;
    assign o_sts.mod_idle  = mod_idle;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

`ifndef SYNTH
    a_off_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_off_stale |-> (raq_pkg::LEN_W'(r_off) < eff_len))
        else $error("held offset is not below the length");

    a_out_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result is not shown as valid");
`endif

endmodule

// ===== src/raq_ctrl.sv =====
module raq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  raq_pkg::t_sts    i_sts,
    output raq_pkg::t_cmd    o_cmd
);

    raq_pkg::t_state r_state;
    raq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= raq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            raq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = raq_pkg::ST_DISPATCH;
                end
            end
            raq_pkg::ST_DISPATCH: begin
                if (i_sts.req == raq_pkg::REQ_LOAD) begin
                    n_state = raq_pkg::ST_IDLE;
                end else if (i_sts.off_stale) begin
                    n_state = raq_pkg::ST_OFF_RUN;
                end else begin
                    n_state = raq_pkg::ST_OPND_RUN;
                end
            end
            raq_pkg::ST_OFF_RUN: begin
                if (i_sts.mod_idle) begin
                    n_state = raq_pkg::ST_OPND_RUN;
                end
            end
            raq_pkg::ST_OPND_RUN: begin
                if (i_sts.mod_idle) begin
                    n_state = (i_sts.req == raq_pkg::REQ_QUERY) ? raq_pkg::ST_READ
                                                                : raq_pkg::ST_IDLE;
                end
            end
            raq_pkg::ST_READ: begin
                if (i_sts.out_free) begin
                    n_state = raq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = raq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            raq_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            raq_pkg::ST_DISPATCH: begin
                if (i_sts.req == raq_pkg::REQ_LOAD) begin
                    o_cmd.mem_write = 1'b1;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_off   = i_sts.off_stale;
                end
            end
            raq_pkg::ST_OFF_RUN: begin
                if (i_sts.mod_idle) begin
                    o_cmd.off_load  = 1'b1;
                    o_cmd.mod_start = 1'b1;
                end
            end
            raq_pkg::ST_OPND_RUN: begin
                if (i_sts.mod_idle) begin
                    if (i_sts.req == raq_pkg::REQ_QUERY) begin
                        o_cmd.mem_read = 1'b1;
                    end else begin
                        o_cmd.rot_apply = 1'b1;
                    end
                end
            end
            raq_pkg::ST_READ: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mod_start |-> i_sts.mod_idle)
        else $error("modulo unit started while busy");

    a_accept_dispatch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == raq_pkg::ST_DISPATCH))
        else $error("accepted beat was not dispatched");
`endif

endmodule

// ===== src/rotated_array_query_top.sv =====
// Channel   Direction  Handshake                  Beat
// input     in         i_in_valid / o_in_stall    raq_pkg::t_in_item
// output    out        o_out_valid / i_out_stall  raq_pkg::t_out_item
// config    in         i_cfg_we                   i_cfg_data (array length)
//
// A load is captured, then written to storage; a rotate or query first runs its operand
// through the restoring modulo unit, which retires one dividend bit per cycle.
// After a length write, the next rotate or query first reduces the held offset
// modulo the new length in a separate pass of the same unit.
// Reset clears the offset and sets the length to one; element storage is kept.
// A query waits in its final state while the output register is full and stalled.
module rotated_array_query_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [raq_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  raq_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output raq_pkg::t_out_item           o_out_item
);

    raq_pkg::t_cmd cmd;
    raq_pkg::t_sts sts;

    raq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    raq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
